>>> rtl/aba_pkg.sv
// Shared definitions for the aligned bump allocator: field widths, default sizes,
// status codes, register indexes and register reset values.
// No dependencies.
package aba_pkg;

	// default sizing of the pool and slot table
	localparam int DEF_SLOT_COUNT     = 128;
	localparam int DEF_POOL_BYTES     = 4096;
	localparam int DEF_MAX_ITEM_BYTES = 512;

	// word field widths
	localparam int REQ_W    = 10;
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 3;
	localparam int OFF_W    = 13;
	localparam int SLOTS_W  = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ALIGN_W    = 3;
	localparam int LIMIT_W    = 13;
	localparam int GAP_W      = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_BYTES  = 2'd2;

	localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2 = 3'd2;
	localparam logic [LIMIT_W-1:0] RST_POOL_LIMIT = 13'd4096;
	localparam logic [GAP_W-1:0]   RST_GAP_BYTES  = 7'd0;

	// operation kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_RANGE   = 3'd3,
		ST_DELETED = 3'd4
	} status_t;

endpackage

>>> rtl/aligned_bump_allocator.sv
// Aligned bump allocator: sequencer, slot table memory and shared pointer arithmetic.
// Depends on aba_pkg.
//
// Use: an input word on in_valid/in_ready is either an allocate (kind 0: request_bytes,
// apply_gap) or a free (kind 1: slot_index). Each input word yields exactly one result
// word on out_valid/out_ready with a status, the placement of a new allocation and the
// allocator state after the item. Registers align_log2, pool_limit and gap_bytes are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while no
// item is in flight, as the block does not enforce it. The block takes one word at a
// time; in_ready is high only while idle. An allocate is accepted, then makes one pass
// through the bump/align/limit adder. A free reads its slot on accept; if it frees the
// tail above slot zero, a walk follows that reads one slot per deleted slot below it,
// plus the live slot it stops on, if any, bound by the single read port of the slot table.
// The result register sits between the sequencer and the output: a new word is
// accepted while the previous result still waits. If the receiver stalls when the
// next result is ready, the sequencer parks in a hold state until the output frees.
// Reset clears the bump pointer, slot count, byte total and loads the register
// defaults (align 4 bytes, limit 4096, no gap). The slot table is not cleared: only
// entries below the slot count are ever used.
module aligned_bump_allocator #(
	parameter int SLOT_COUNT     = aba_pkg::DEF_SLOT_COUNT,
	parameter int POOL_BYTES     = aba_pkg::DEF_POOL_BYTES,
	parameter int MAX_ITEM_BYTES = aba_pkg::DEF_MAX_ITEM_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [aba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aba_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [aba_pkg::REQ_W-1:0]       request_bytes,
	input  logic                            apply_gap,
	input  logic [aba_pkg::IDX_W-1:0]       slot_index,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [aba_pkg::STATUS_W-1:0]    status,
	output logic [aba_pkg::OFF_W-1:0]       placed_offset,
	output logic [aba_pkg::IDX_W-1:0]       placed_slot,
	output logic [aba_pkg::OFF_W-1:0]       bump_after,
	output logic [aba_pkg::OFF_W-1:0]       bytes_in_use,
	output logic [aba_pkg::SLOTS_W-1:0]     slots_in_use
);
	import aba_pkg::*;

	// slot address, slot count and pool pointer widths
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int BUMP_W = $clog2(POOL_BYTES + 1);
	// place can reach the pool end plus alignment slack and gap; end adds a request
	localparam int SUM_RAW = $clog2(POOL_BYTES + 1280);
	localparam int XW      = (SUM_RAW > OFF_W) ? SUM_RAW : OFF_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALLOC = 5'b00010,
		S_FREE  = 5'b00100,
		S_WALK  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [BUMP_W-1:0] offset;
		logic [REQ_W-1:0]  size;
		logic              deleted;
	} entry_t;

	// configuration registers
	logic [ALIGN_W-1:0] align_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [GAP_W-1:0]   gap_q;

	// allocator state
	state_t            state_q, state_d;
	logic [BUMP_W-1:0] bump_q, bump_d;
	logic [BUMP_W-1:0] total_q, total_d;
	logic [CNT_W-1:0]  count_q, count_d;

	// latched request word
	logic [REQ_W-1:0]  req_q;
	logic              gap_on_q;
	logic [IDX_W-1:0]  idx_q;

	// slot table
	entry_t            mem [SLOT_COUNT];
	entry_t            rd_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;
	logic [SLOT_W-1:0] mem_ra;
	entry_t            mem_wd;

	// result register and parked result
	logic              out_valid_q;
	status_t           out_status_q;
	logic [OFF_W-1:0]  out_off_q;
	logic [IDX_W-1:0]  out_slot_q;
	logic [OFF_W-1:0]  out_bump_q;
	logic [OFF_W-1:0]  out_total_q;
	logic [SLOTS_W-1:0] out_count_q;
	status_t           pend_status_q;
	logic [XW-1:0]     pend_off_q;
	logic [CNT_W-1:0]  pend_slot_q;

	// finishing result from the sequencer
	logic              fin;
	status_t           fin_status;
	logic [XW-1:0]     fin_off;
	logic [CNT_W-1:0]  fin_slot;
	logic              out_free;
	logic              in_fire;

	// shared pointer arithmetic
	logic [XW-1:0] bump_x, mask_x, aligned_x, place_x, end_x, limit_x, pool_x;
	logic [XW-1:0] idx_x, in_idx_x, count_x, total_add_x, tail_end_x;
	logic [CNT_W-1:0] walk_addr;
	logic          full, oversize, fits;

	// result conversion to port widths
	logic [XW-1:0] ld_off_x, ld_slot_x, ld_bump_x, ld_total_x, ld_count_x;
	status_t       ld_status;
	logic          ld_en;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// hold the configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= RST_ALIGN_LOG2;
			limit_q <= RST_POOL_LIMIT;
			gap_q   <= RST_GAP_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALIGN_LOG2: align_q <= cfg_data[ALIGN_W-1:0];
				CFG_POOL_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_GAP_BYTES:  gap_q   <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// round the bump pointer up, add the gap if requested, then the request; clamp the limit to the pool
	assign pool_x      = XW'(POOL_BYTES);
	assign bump_x      = XW'(bump_q);
	assign mask_x      = (XW'(1) << align_q) - XW'(1);
	assign aligned_x   = (bump_x + mask_x) & ~mask_x;
	assign place_x     = aligned_x + (gap_on_q ? XW'(gap_q) : XW'(0));
	assign end_x       = place_x + XW'(req_q);
	assign limit_x     = (XW'(limit_q) > pool_x) ? pool_x : XW'(limit_q);
	assign full        = (count_q == CNT_W'(SLOT_COUNT));
	assign oversize    = (XW'(req_q) > XW'(MAX_ITEM_BYTES));
	assign fits        = (end_x <= limit_x);
	assign total_add_x = XW'(total_q) + XW'(req_q);
	assign tail_end_x  = XW'(rd_q.offset) + XW'(rd_q.size);
	assign idx_x       = XW'(idx_q);
	assign in_idx_x    = XW'(slot_index);
	assign count_x     = XW'(count_q);
	assign walk_addr   = count_d - CNT_W'(1);

	// sequencer
	always_comb begin
		state_d    = state_q;
		bump_d     = bump_q;
		total_d    = total_q;
		count_d    = count_q;
		mem_we     = 1'b0;
		mem_wa     = count_q[SLOT_W-1:0];
		mem_wd     = rd_q;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_off    = '0;
		fin_slot   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (kind == KIND_FREE) ? S_FREE : S_ALLOC;
				end
			end
			S_ALLOC: begin
				fin = 1'b1;
				if (full) begin
					fin_status = ST_FULL;
				end else if (oversize || !fits) begin
					fin_status = ST_NOSPACE;
				end else begin
					mem_we         = 1'b1;
					mem_wd.offset  = place_x[BUMP_W-1:0];
					mem_wd.size    = req_q;
					mem_wd.deleted = 1'b0;
					bump_d         = end_x[BUMP_W-1:0];
					total_d        = total_add_x[BUMP_W-1:0];
					count_d        = count_q + CNT_W'(1);
					fin_off        = place_x;
					fin_slot       = count_q;
				end
			end
			S_FREE: begin
				// rd_q holds the entry at idx_q, read on accept
				if (idx_x >= count_x) begin
					fin        = 1'b1;
					fin_status = ST_RANGE;
				end else if (rd_q.deleted) begin
					fin        = 1'b1;
					fin_status = ST_DELETED;
				end else begin
					mem_we         = 1'b1;
					mem_wa         = idx_x[SLOT_W-1:0];
					mem_wd.deleted = 1'b1;
					total_d        = total_q - BUMP_W'(rd_q.size);
					if (idx_x + XW'(1) == count_x) begin
						count_d = idx_x[CNT_W-1:0];
						if (idx_x == XW'(0)) begin
							bump_d = '0;
							fin    = 1'b1;
						end else begin
							state_d = S_WALK;
						end
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_WALK: begin
				// rd_q holds the entry just below count_q
				if (rd_q.deleted) begin
					count_d = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						bump_d = '0;
						fin    = 1'b1;
					end
				end else begin
					bump_d = tail_end_x[BUMP_W-1:0];
					fin    = 1'b1;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_RESP;
		end
	end

	// read on accept for a free, else read below the next slot count for the walk
	assign mem_ra = (state_q == S_IDLE) ? in_idx_x[SLOT_W-1:0] : walk_addr[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bump_q  <= '0;
			total_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			bump_q  <= bump_d;
			total_q <= total_d;
			count_q <= count_d;
		end
	end

	// latch the request word and park a finished result the output cannot take
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q    <= request_bytes;
			gap_on_q <= apply_gap;
			idx_q    <= slot_index;
		end
		if (fin && !out_free) begin
			pend_status_q <= fin_status;
			pend_off_q    <= fin_off;
			pend_slot_q   <= fin_slot;
		end
	end

	// load the result register straight from the sequencer or from the parked result
	always_comb begin
		ld_en      = 1'b0;
		ld_status  = fin_status;
		ld_off_x   = fin_off;
		ld_slot_x  = XW'(fin_slot);
		ld_bump_x  = XW'(bump_d);
		ld_total_x = XW'(total_d);
		ld_count_x = XW'(count_d);
		if (fin && out_free) begin
			ld_en = 1'b1;
		end else if (state_q == S_RESP && out_free) begin
			ld_en      = 1'b1;
			ld_status  = pend_status_q;
			ld_off_x   = pend_off_q;
			ld_slot_x  = XW'(pend_slot_q);
			ld_bump_x  = XW'(bump_q);
			ld_total_x = XW'(total_q);
			ld_count_x = XW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			out_status_q <= ld_status;
			out_off_q    <= ld_off_x[OFF_W-1:0];
			out_slot_q   <= ld_slot_x[IDX_W-1:0];
			out_bump_q   <= ld_bump_x[OFF_W-1:0];
			out_total_q  <= ld_total_x[OFF_W-1:0];
			out_count_q  <= ld_count_x[SLOTS_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign placed_offset = out_off_q;
	assign placed_slot   = out_slot_q;
	assign bump_after    = out_bump_q;
	assign bytes_in_use  = out_total_q;
	assign slots_in_use  = out_count_q;

	// the slot count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOT_COUNT))
		else $error("slot count above table size");

	// an empty table leaves nothing placed and nothing held
	a_empty_state: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (bump_q == '0 && total_q == '0))
		else $error("empty table with nonzero bump pointer or byte total");

	// live bytes all lie below the bump pointer
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= bump_q)
		else $error("byte total above bump pointer");

	// an accepted word starts work at once
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_ALLOC || state_q == S_FREE))
		else $error("accepted word did not start");

	// a result finished against a stalled output is parked
	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		fin && !out_free |=> state_q == S_RESP && out_valid_q)
		else $error("finished result not parked");

endmodule
